@@ sv/mpfb_pkg.sv @@
// shared types and constants of the page-organized monochrome frame store
// no dependencies; used by mpfb_store and mono_page_framebuffer_top
`default_nettype none

package mpfb_pkg;

  // default geometry: columns and eight-row pages
  localparam int unsigned DefColumns = 128;
  localparam int unsigned DefPages   = 4;

  // fixed field widths of the request and result
  localparam int unsigned XW    = 7;
  localparam int unsigned YW    = 5;
  localparam int unsigned ByteW = 8;

  // request opcodes
  typedef enum logic [1:0] {
    OpPoint = 2'd0,
    OpFill  = 2'd1,
    OpClear = 2'd2,
    OpRead  = 2'd3
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StWrite  = 4'b0010,
    StRdNext = 4'b0100,
    StRead   = 4'b1000
  } state_e;

  // control strobes from the sequencer to the column store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mpfb_store.sv @@
// column store: one word of PAGES bytes per column, registered read port
// with per-column valid bits so that reset and clear take effect at once
// depends on mpfb_pkg
`default_nettype none

module mpfb_store #(
  parameter int unsigned COLUMNS = mpfb_pkg::DefColumns,
  parameter int unsigned PAGES   = mpfb_pkg::DefPages
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mpfb_pkg::mem_ctrl_t          ctrl_i,
  input  wire logic [$clog2(COLUMNS)-1:0]   rd_addr_i,
  input  wire logic [$clog2(COLUMNS)-1:0]   wr_addr_i,
  input  wire logic [PAGES*8-1:0]           wr_data_i,
  output logic      [PAGES*8-1:0]           rd_data_o
);

  localparam int unsigned W  = PAGES * 8;

  logic [W-1:0]       mem [COLUMNS];
  logic [W-1:0]       rdata_q;
  logic [COLUMNS-1:0] valid_q;
  logic               rvalid_q;

  // memory array: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // valid bits: a column never written since reset or clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ sv/mono_page_framebuffer_top.sv @@
// top level of the monochrome page frame store: request decode and the
// read-modify-write sequencer that walks columns; depends on mpfb_pkg, mpfb_store
`default_nettype none

// Usage
//   A request is taken at a rising edge where start is high and busy is low.
//   Every request gives one result: done_o is high for exactly one cycle and
//   read_data_o carries the byte (read requests) or zero (all others). The
//   receiver cannot hold results off; done_o is simply a one-cycle strobe.
// Sequencing
//   Point draw and byte read: the column word is read as the request is taken,
//   then busy while StWrite or StRead runs; done_o comes as busy falls.
//   Rectangle fill over n stored columns: one read-modify-write of the column
//   word per column through the single memory port pair, read (StRdNext, or the
//   request itself for the first) then written (StWrite); done_o as busy falls.
//   Clear all, and a rectangle or point that touches no stored pixel: done_o
//   in the cycle after the request and busy stays low, so no request is held off.
// Reset
//   rst_ni clears per-column valid bits at once, so the whole store reads as
//   dark right after reset; no clearing pass is needed.
module mono_page_framebuffer_top #(
  parameter int unsigned COLUMNS = mpfb_pkg::DefColumns,
  parameter int unsigned PAGES   = mpfb_pkg::DefPages
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [mpfb_pkg::XW-1:0]     x_first_i,
  input  wire logic [mpfb_pkg::YW-1:0]     y_first_i,
  input  wire logic [mpfb_pkg::XW-1:0]     x_last_i,
  input  wire logic [mpfb_pkg::YW-1:0]     y_last_i,
  input  wire logic                        pixel_value_i,
  input  wire logic [mpfb_pkg::XW-1:0]     read_column_i,
  input  wire logic [1:0]                  read_page_i,
  output logic                             done_o,
  output logic [mpfb_pkg::ByteW-1:0]       read_data_o
);

  localparam int unsigned W    = PAGES * 8;
  localparam int unsigned ROWS = PAGES * 8;
  localparam int unsigned CW   = $clog2(COLUMNS);
  localparam int unsigned PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [8:0]  ColLim  = 9'(COLUMNS);
  localparam logic [6:0]  RowLim  = 7'(ROWS);
  localparam logic [3:0]  PageLim = 4'(PAGES);
  localparam logic [CW-1:0] ColMax = CW'(COLUMNS - 1);

  mpfb_pkg::state_e    state_q, state_d;
  mpfb_pkg::mem_ctrl_t ctrl;

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] xhi_q, xhi_d;
  logic [W-1:0]  mask_q, mask_d;
  logic          on_q, on_d;
  logic [PW-1:0] page_q, page_d;
  logic          done_q, done_d;
  logic [mpfb_pkg::ByteW-1:0] rdata_q, rdata_d;

  logic [CW-1:0] rd_addr;
  logic [W-1:0]  rd_word;
  logic [W-1:0]  wr_word;

  logic                    accept;
  logic [mpfb_pkg::XW-1:0] in_col;
  logic [mpfb_pkg::XW-1:0] x_hi_raw;
  logic [mpfb_pkg::YW-1:0] y_hi_raw;
  logic                    region_empty;
  logic                    rd_ok;

  assign accept = start && !busy;
  assign busy   = (state_q != mpfb_pkg::StIdle);

  // region of a point or rectangle request
  assign x_hi_raw = (mpfb_pkg::op_e'(opcode_i) == mpfb_pkg::OpPoint) ? x_first_i : x_last_i;
  assign y_hi_raw = (mpfb_pkg::op_e'(opcode_i) == mpfb_pkg::OpPoint) ? y_first_i : y_last_i;
  assign region_empty = (x_first_i > x_hi_raw) || (y_first_i > y_hi_raw) ||
                        ({2'b00, x_first_i} >= ColLim) || ({2'b00, y_first_i} >= RowLim);
  assign rd_ok = ({2'b00, read_column_i} < ColLim) && ({2'b00, read_page_i} < PageLim);
  assign in_col = (mpfb_pkg::op_e'(opcode_i) == mpfb_pkg::OpRead) ? read_column_i : x_first_i;

  // row mask over the stored rows, rows past the store drop out by width
  always_comb begin
    for (int r = 0; r < int'(ROWS); r++) begin
      mask_d[r] = (7'(r) >= {2'b00, y_first_i}) && (7'(r) <= {2'b00, y_hi_raw});
    end
  end

  // modified column word
  assign wr_word = (rd_word & ~mask_q) | (on_q ? mask_q : '0);

  // sequencer
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    xhi_d    = xhi_q;
    on_d     = on_q;
    page_d   = page_q;
    done_d   = 1'b0;
    rdata_d  = '0;
    ctrl     = '0;
    rd_addr  = col_q;
    case (state_q)
      mpfb_pkg::StIdle: begin
        rd_addr = CW'(in_col);
        if (accept) begin
          case (mpfb_pkg::op_e'(opcode_i))
            mpfb_pkg::OpPoint, mpfb_pkg::OpFill: begin
              col_d = CW'(x_first_i);
              xhi_d = ({2'b00, x_hi_raw} >= ColLim) ? ColMax : CW'(x_hi_raw);
              on_d  = pixel_value_i;
              if (region_empty) begin
                done_d = 1'b1;
              end else begin
                ctrl.rd_en = 1'b1;
                state_d    = mpfb_pkg::StWrite;
              end
            end
            mpfb_pkg::OpClear: begin
              ctrl.clr = 1'b1;
              done_d   = 1'b1;
            end
            mpfb_pkg::OpRead: begin
              page_d = PW'(read_page_i);
              if (rd_ok) begin
                ctrl.rd_en = 1'b1;
                state_d    = mpfb_pkg::StRead;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      mpfb_pkg::StWrite: begin
        ctrl.wr_en = 1'b1;
        if (col_q == xhi_q) begin
          done_d  = 1'b1;
          state_d = mpfb_pkg::StIdle;
        end else begin
          col_d   = CW'(col_q + 1'b1);
          state_d = mpfb_pkg::StRdNext;
        end
      end
      mpfb_pkg::StRdNext: begin
        ctrl.rd_en = 1'b1;
        state_d    = mpfb_pkg::StWrite;
      end
      mpfb_pkg::StRead: begin
        done_d  = 1'b1;
        rdata_d = rd_word[8*int'(page_q) +: 8];
        state_d = mpfb_pkg::StIdle;
      end
      default: begin
        state_d = mpfb_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpfb_pkg::StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // request payload and result byte
  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    xhi_q   <= xhi_d;
    on_q    <= on_d;
    page_q  <= page_d;
    rdata_q <= rdata_d;
    if (accept) begin
      mask_q <= mask_d;
    end
  end

  mpfb_store #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (col_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  assign done_o      = done_q;
  assign read_data_o = rdata_q;

endmodule

`default_nettype wire
